>>> design/risc16_instruction_executor_unit_assert.svh
// assertion macros shared by the checker
`ifndef RISC16_INSTRUCTION_EXECUTOR_UNIT_ASSERT_SVH
`define RISC16_INSTRUCTION_EXECUTOR_UNIT_ASSERT_SVH
`define RIE_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define RIE_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

>>> design/rie_pkg.sv
// ----------------------------------------------------------------------------
// rie_pkg
// types and constants shared by the instruction executor modules
// ----------------------------------------------------------------------------
`default_nettype none
package rie_pkg;
	localparam logic [1:0] FUNC_LOAD = 2'd0;
	localparam logic [1:0] FUNC_EXEC = 2'd1;
	localparam logic [1:0] FUNC_READ = 2'd2;

	localparam logic [3:0] OP_BR     = 4'd0;
	localparam logic [3:0] OP_ARITH  = 4'd1;
	localparam logic [3:0] OP_CMP    = 4'd2;
	localparam logic [3:0] OP_JSR    = 4'd4;
	localparam logic [3:0] OP_LOGIC  = 4'd5;
	localparam logic [3:0] OP_LDR    = 4'd6;
	localparam logic [3:0] OP_STR    = 4'd7;
	localparam logic [3:0] OP_RTI    = 4'd8;
	localparam logic [3:0] OP_CONST  = 4'd9;
	localparam logic [3:0] OP_SHIFT  = 4'd10;
	localparam logic [3:0] OP_JMP    = 4'd12;
	localparam logic [3:0] OP_HICON  = 4'd13;
	localparam logic [3:0] OP_TRAP   = 4'd15;

	localparam logic [15:0] PC_RESET  = 16'h8200;
	localparam logic [15:0] PSR_RESET = 16'h8002;

	typedef struct packed {
		logic [15:0] read_value;
		logic [15:0] next_pc;
		logic [15:0] status_word;
		logic        reg_write;
		logic [2:0]  reg_index;
		logic [15:0] reg_value;
		logic        mem_write;
		logic [15:0] store_addr;
		logic [15:0] store_value;
		logic        illegal;
	} result_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] word_addr;
		logic [15:0] load_value;
	} item_t;

	// controller to datapath
	typedef struct packed {
		logic take;       // latch input item
		logic mem_item;   // issue load/read access
		logic fetch;      // issue instruction fetch
		logic decode;     // latch instruction, read operands
		logic exec;       // compute, start divide, issue data access
		logic commit;     // write state, form result
	} cmd_t;

	typedef struct packed {
		logic div_busy;
	} sts_t;
endpackage
`default_nettype wire

>>> design/rie_stream_if.sv
// ----------------------------------------------------------------------------
// rie_stream_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
`default_nettype none
interface rie_stream_if #(parameter int W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/rie_ram.sv
// ----------------------------------------------------------------------------
// rie_ram
// single port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module rie_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

>>> design/rie_divider.sv
// ----------------------------------------------------------------------------
// rie_divider
// restoring divider, one quotient bit a cycle, zero divisor gives zeros
// ----------------------------------------------------------------------------
`default_nettype none
module rie_divider (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [15:0] dividend,
	input  wire logic [15:0] divisor,
	output logic             busy,
	output logic [15:0]      quotient,
	output logic [15:0]      remainder
);
	logic [15:0] quo_q;
	logic [15:0] rem_q;
	logic [15:0] dsr_q;
	logic [4:0]  cnt_q;
	logic        zero_q;
	logic [16:0] trial;
	logic [16:0] shifted;

	assign shifted = {rem_q, quo_q[15]};
	assign trial = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 5'd16;
		end else if (cnt_q != 5'd0) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q  <= dividend;
			rem_q  <= '0;
			dsr_q  <= divisor;
			zero_q <= (divisor == 16'd0);
		end else if (cnt_q != 5'd0) begin
			if (!trial[16]) begin
				rem_q <= trial[15:0];
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= shifted[15:0];
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
	end

	assign busy      = (cnt_q != 5'd0);
	assign quotient  = zero_q ? 16'd0 : quo_q;
	assign remainder = zero_q ? 16'd0 : rem_q;
endmodule
`default_nettype wire

>>> design/rie_datapath.sv
// ----------------------------------------------------------------------------
// rie_datapath
// architectural state, memory, decode and execute logic
// ----------------------------------------------------------------------------
`default_nettype none
module rie_datapath #(
	parameter int ADDR_BITS = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire rie_pkg::cmd_t  cmd,
	output rie_pkg::sts_t       sts,
	input  wire rie_pkg::item_t item,
	output rie_pkg::result_t    result
);
	logic [15:0] pc_q;
	logic [15:0] psr_q;
	logic [15:0] regs_q [8];
	rie_pkg::item_t item_q;
	logic [15:0] insn_q;
	logic [15:0] rs_q;
	logic [15:0] rt_q;
	logic [15:0] rd_q;
	logic [15:0] prod_q;

	logic                 ram_we;
	logic [ADDR_BITS-1:0] ram_addr;
	logic [15:0]          ram_wdata;
	logic [15:0]          ram_rdata;

	logic        div_busy;
	logic [15:0] quo;
	logic [15:0] rem;

	rie_ram #(.WIDTH(16), .DEPTH(1 << ADDR_BITS)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	logic [3:0]  op;
	logic [2:0]  sub;
	logic [15:0] pc1;
	logic [15:0] sx5;
	logic [15:0] sx6;
	logic [15:0] sx7;
	logic [15:0] sx9;
	logic [15:0] sx11;
	logic [15:0] mem_ea;
	logic        div_op;

	assign op   = insn_q[15:12];
	assign sub  = insn_q[5:3];
	assign pc1  = pc_q + 16'd1;
	assign sx5  = {{11{insn_q[4]}}, insn_q[4:0]};
	assign sx6  = {{10{insn_q[5]}}, insn_q[5:0]};
	assign sx7  = {{9{insn_q[6]}}, insn_q[6:0]};
	assign sx9  = {{7{insn_q[8]}}, insn_q[8:0]};
	assign sx11 = {{5{insn_q[10]}}, insn_q[10:0]};
	assign mem_ea = rs_q + sx6;

	// only div and mod run the divider
	assign div_op = ((op == rie_pkg::OP_ARITH) && (sub == 3'd3)) ||
		((op == rie_pkg::OP_SHIFT) && (insn_q[5:4] == 2'd3));

	rie_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.exec && div_op),
		.dividend (rs_q),
		.divisor  (rt_q),
		.busy     (div_busy),
		.quotient (quo),
		.remainder(rem)
	);
	assign sts.div_busy = div_busy;

	// memory port: item access, fetch, data access
	// during an instruction the address rests on the data address so load data holds
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = (item_q.func == rie_pkg::FUNC_EXEC) ? mem_ea[ADDR_BITS-1:0] :
			item_q.word_addr[ADDR_BITS-1:0];
		ram_wdata = item_q.load_value;
		if (cmd.mem_item) begin
			ram_we = (item_q.func == rie_pkg::FUNC_LOAD);
		end else if (cmd.fetch) begin
			ram_addr = pc_q[ADDR_BITS-1:0];
		end else if (cmd.exec) begin
			ram_addr  = mem_ea[ADDR_BITS-1:0];
			ram_wdata = rd_q;
			ram_we    = (op == rie_pkg::OP_STR);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			item_q <= item;
		end
		if (cmd.decode) begin
			insn_q <= ram_rdata;
			rs_q   <= regs_q[ram_rdata[8:6]];
			rt_q   <= regs_q[ram_rdata[2:0]];
			rd_q   <= regs_q[ram_rdata[11:9]];
		end
		if (cmd.exec) begin
			prod_q <= 16'(rs_q * rt_q);
		end
	end

	// execute
	logic [15:0] val;
	logic [2:0]  widx;
	logic        wr;
	logic        st;
	logic        ill;
	logic [15:0] npc;
	logic [15:0] npsr;
	logic [2:0]  cmp_nzp;
	logic        cmp_set;
	logic [3:0]  amt;
	logic [31:0] sra_ext;

	assign amt = insn_q[3:0];
	assign sra_ext = {{16{rs_q[15]}}, rs_q} >> amt;

	function automatic logic [2:0] cmp3s(input logic [15:0] a, input logic [15:0] b);
		if ($signed(a) < $signed(b)) return 3'd4;
		if (a == b) return 3'd2;
		return 3'd1;
	endfunction

	function automatic logic [2:0] cmp3u(input logic [15:0] a, input logic [15:0] b);
		if (a < b) return 3'd4;
		if (a == b) return 3'd2;
		return 3'd1;
	endfunction

	always_comb begin
		val     = '0;
		widx    = insn_q[11:9];
		wr      = 1'b0;
		st      = 1'b0;
		ill     = 1'b0;
		npc     = pc1;
		npsr    = psr_q;
		cmp_nzp = 3'd0;
		cmp_set = 1'b0;
		case (op)
			rie_pkg::OP_BR: begin
				if ((insn_q[11:9] & psr_q[2:0]) != 3'd0) npc = pc1 + sx9;
			end
			rie_pkg::OP_ARITH: begin
				wr = 1'b1;
				case (sub)
					3'd0: val = rs_q + rt_q;
					3'd1: val = prod_q;
					3'd2: val = rs_q - rt_q;
					3'd3: val = quo;
					default: val = rs_q + sx5;
				endcase
			end
			rie_pkg::OP_CMP: begin
				cmp_set = 1'b1;
				case (insn_q[8:7])
					2'd0: cmp_nzp = cmp3s(rd_q, rt_q);
					2'd1: cmp_nzp = cmp3u(rd_q, rt_q);
					2'd2: cmp_nzp = cmp3s(rd_q, sx7);
					default: cmp_nzp = cmp3u(rd_q, {9'd0, insn_q[6:0]});
				endcase
			end
			rie_pkg::OP_JSR: begin
				wr = 1'b1; widx = 3'd7; val = pc1;
				if (insn_q[11]) npc = {pc_q[15], insn_q[10:0], 4'd0};
				else npc = rs_q;
			end
			rie_pkg::OP_LOGIC: begin
				wr = 1'b1;
				case (sub)
					3'd0: val = rs_q & rt_q;
					3'd1: val = ~rs_q;
					3'd2: val = rs_q | rt_q;
					3'd3: val = rs_q ^ rt_q;
					default: val = rs_q & sx5;
				endcase
			end
			rie_pkg::OP_LDR: begin
				wr = 1'b1; val = ram_rdata;
			end
			rie_pkg::OP_STR: st = 1'b1;
			rie_pkg::OP_RTI: begin
				npc = regs_q[7];
				npsr[15] = 1'b0;
			end
			rie_pkg::OP_CONST: begin
				wr = 1'b1; val = sx9;
			end
			rie_pkg::OP_SHIFT: begin
				wr = 1'b1;
				case (insn_q[5:4])
					2'd0: val = rs_q << amt;
					2'd1: val = sra_ext[15:0];
					2'd2: val = rs_q >> amt;
					default: val = rem;
				endcase
			end
			rie_pkg::OP_JMP: begin
				if (insn_q[11]) npc = pc1 + sx11;
				else npc = rs_q;
			end
			rie_pkg::OP_HICON: begin
				wr = 1'b1; val = {insn_q[7:0], rd_q[7:0]};
			end
			rie_pkg::OP_TRAP: begin
				wr = 1'b1; widx = 3'd7; val = pc1;
				npc = {8'h80, insn_q[7:0]};
				npsr[15] = 1'b1;
			end
			default: begin
				ill = 1'b1;
				npc = pc_q;
			end
		endcase
		if (cmp_set) npsr[2:0] = cmp_nzp;
		if (wr) npsr[2:0] = val[15] ? 3'd4 : ((val == 16'd0) ? 3'd2 : 3'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= rie_pkg::PC_RESET;
			psr_q <= rie_pkg::PSR_RESET;
			for (int i = 0; i < 8; i++) regs_q[i] <= '0;
		end else if (cmd.commit && item_q.func == rie_pkg::FUNC_EXEC) begin
			pc_q  <= npc;
			psr_q <= npsr;
			if (wr) regs_q[widx] <= val;
		end
	end

	// result, built from post-commit view
	always_comb begin
		result = '0;
		result.next_pc     = pc_q;
		result.status_word = psr_q;
		if (item_q.func == rie_pkg::FUNC_READ) begin
			result.read_value = ram_rdata;
		end else if (item_q.func == rie_pkg::FUNC_EXEC) begin
			result.next_pc     = npc;
			result.status_word = npsr;
			result.illegal     = ill;
			if (wr) begin
				result.reg_write = 1'b1;
				result.reg_index = widx;
				result.reg_value = val;
			end
			if (st) begin
				result.mem_write   = 1'b1;
				result.store_addr  = {{(16-ADDR_BITS){1'b0}}, mem_ea[ADDR_BITS-1:0]};
				result.store_value = rd_q;
			end
		end
	end
endmodule
`default_nettype wire

>>> design/rie_controller.sv
// ----------------------------------------------------------------------------
// rie_controller
// sequencer for item handling and instruction steps, output register
// ----------------------------------------------------------------------------
`default_nettype none
module rie_controller (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [1:0]       in_func,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output rie_pkg::cmd_t         cmd,
	input  wire rie_pkg::sts_t    sts,
	input  wire rie_pkg::result_t result,
	output rie_pkg::result_t      out_data
);
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_MEM    = 3'd1;
	localparam logic [2:0] S_FETCH  = 3'd2;
	localparam logic [2:0] S_DECODE = 3'd3;
	localparam logic [2:0] S_EXEC   = 3'd4;
	localparam logic [2:0] S_WAIT   = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	rie_pkg::result_t out_q;
	logic       take;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign take      = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		cmd.take = take;
		state_d = state_q;
		case (state_q)
			S_IDLE: if (take) state_d = (in_func == rie_pkg::FUNC_EXEC) ? S_FETCH : S_MEM;
			S_MEM: begin
				cmd.mem_item = 1'b1;
				state_d = S_DONE;
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
				state_d = S_DECODE;
			end
			S_DECODE: begin
				cmd.decode = 1'b1;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d = S_WAIT;
			end
			S_WAIT: if (!sts.div_busy) state_d = S_DONE;
			S_DONE: begin
				// commit only when the output slot can take the result
				if (slot_free) begin
					cmd.commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) out_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule
`default_nettype wire

>>> design/risc16_instruction_executor_unit.sv
// a load or read item goes through a memory step and commit, an instruction
// through fetch, decode, execute, settle, commit; div and mod stall in settle
// one item at a time on the single memory port; next item accepted after commit
// reset: pc 0x8200, psr 0x8002, registers zero, memory undefined until written
// ----------------------------------------------------------------------------
// risc16_instruction_executor_unit
// multicycle 16-bit lc4-style instruction executor
// ----------------------------------------------------------------------------
`default_nettype none
module risc16_instruction_executor_unit #(
	parameter int ADDR_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	rie_stream_if.sink   in_ch,
	rie_stream_if.source out_ch
);
	rie_pkg::cmd_t    cmd;
	rie_pkg::sts_t    sts;
	rie_pkg::result_t result;
	rie_pkg::result_t out_data;
	rie_pkg::item_t   item;
	logic             in_ready;
	logic             out_valid;

	assign item = in_ch.data;

	rie_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.in_func  (item.func),
		.out_valid(out_valid),
		.out_ready(out_ch.ready),
		.cmd      (cmd),
		.sts      (sts),
		.result   (result),
		.out_data (out_data)
	);

	rie_datapath #(.ADDR_BITS(ADDR_BITS)) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.sts   (sts),
		.item  (item),
		.result(result)
	);

	assign in_ch.ready  = in_ready;
	assign out_ch.valid = out_valid;
	assign out_ch.data  = out_data;
endmodule
`default_nettype wire

>>> design/rie_checker.sv
// ----------------------------------------------------------------------------
// rie_checker
// port level checks on the executor
// ----------------------------------------------------------------------------
`default_nettype none
`include "risc16_instruction_executor_unit_assert.svh"
module rie_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire rie_pkg::result_t out_data
);
	`RIE_ASSERT_NXT(a_no_take_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`RIE_ASSERT_IMP(a_hold_result, clk, arst_n, $past(out_valid && !out_ready) && arst_n && $past(arst_n), out_valid && $stable(out_data))
	`RIE_ASSERT_IMP(a_illegal_quiet, clk, arst_n, out_valid && out_data.illegal, !out_data.reg_write && !out_data.mem_write)
	`RIE_ASSERT_IMP(a_index_zero, clk, arst_n, out_valid && !out_data.reg_write, out_data.reg_index == 3'd0 && out_data.reg_value == 16'd0)
endmodule

bind risc16_instruction_executor_unit rie_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_ch.valid),
	.in_ready (in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_data (out_ch.data)
);
`default_nettype wire

>>> tb/rie_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rie_tb_pkg
// instruction sub-field codes shared by the stimulus and the checker
// ----------------------------------------------------------------------------
package rie_tb_pkg;
	// arith, bits 5:3 (4..7 is add immediate)
	localparam logic [2:0] ARITH_ADD = 3'd0;
	localparam logic [2:0] ARITH_MUL = 3'd1;
	localparam logic [2:0] ARITH_SUB = 3'd2;
	localparam logic [2:0] ARITH_DIV = 3'd3;
	// logic, bits 5:3 (4..7 is and immediate)
	localparam logic [2:0] LOGIC_AND = 3'd0;
	localparam logic [2:0] LOGIC_NOT = 3'd1;
	localparam logic [2:0] LOGIC_OR  = 3'd2;
	localparam logic [2:0] LOGIC_XOR = 3'd3;
	// compare, bits 8:7
	localparam logic [1:0] CMP_S  = 2'd0;
	localparam logic [1:0] CMP_U  = 2'd1;
	localparam logic [1:0] CMP_IS = 2'd2;
	localparam logic [1:0] CMP_IU = 2'd3;
	// shift, bits 5:4
	localparam logic [1:0] SH_SLL = 2'd0;
	localparam logic [1:0] SH_SRA = 2'd1;
	localparam logic [1:0] SH_SRL = 2'd2;
	localparam logic [1:0] SH_MOD = 2'd3;
	// opcodes with no instruction
	localparam logic [3:0] OP_BAD_A = 4'd3;
	localparam logic [3:0] OP_BAD_B = 4'd11;
	localparam logic [3:0] OP_BAD_C = 4'd14;
	localparam logic [1:0] FUNC_NONE = 2'd3;
	localparam logic [2:0] NZP_N = 3'd4;
	localparam logic [2:0] NZP_Z = 3'd2;
	localparam logic [2:0] NZP_P = 3'd1;
endpackage

>>> tb/rie_exec_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rie_exec_checker
// watches both channels, predicts each result from accepted items and
// compares it field by field with what the executor returns
// ----------------------------------------------------------------------------
module rie_exec_checker
	import rie_pkg::*;
	import rie_tb_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	rie_stream_if in_mon,
	rie_stream_if out_mon,
	output int error_count,
	output int pending,
	output logic [15:0] pc_view,
	output logic [7:0][15:0] reg_view
);
	logic [15:0] mem_img [0:65535];
	logic [15:0] psr_q;
	result_t expected_q[$];

	function automatic logic [15:0] sx(logic [15:0] v, int bits);
		logic [15:0] t;
		t = v << (16 - bits);
		return 16'($signed(t) >>> (16 - bits));
	endfunction

	function automatic logic [2:0] flags_of(logic [15:0] v);
		if (v[15]) return NZP_N;
		if (v == 16'd0) return NZP_Z;
		return NZP_P;
	endfunction

	function automatic logic [2:0] order3(logic sgn, logic [15:0] a, logic [15:0] b);
		if (sgn ? ($signed(a) < $signed(b)) : (a < b)) return NZP_N;
		if (a == b) return NZP_Z;
		return NZP_P;
	endfunction

	task automatic run_item(input item_t it, output result_t r);
		logic [15:0] insn, rs, rt, rd, pc1, npc, val, saddr;
		logic [2:0] d, s, t, widx, sub;
		logic wr, st;
		r = '0;
		if (it.func == FUNC_LOAD) mem_img[it.word_addr] = it.load_value;
		else if (it.func == FUNC_READ) r.read_value = mem_img[it.word_addr];
		else if (it.func == FUNC_EXEC) begin
			insn = mem_img[pc_view];
			d = insn[11:9];
			s = insn[8:6];
			t = insn[2:0];
			rs = reg_view[s];
			rt = reg_view[t];
			rd = reg_view[d];
			sub = insn[5:3];
			pc1 = pc_view + 16'd1;
			npc = pc1;
			val = '0;
			widx = d;
			wr = 1'b0;
			st = 1'b0;
			saddr = '0;
			case (insn[15:12])
				OP_BR: if (insn[11:9] & psr_q[2:0]) npc = pc1 + sx(insn, 9);
				OP_ARITH: begin
					wr = 1'b1;
					case (sub)
						ARITH_ADD: val = rs + rt;
						ARITH_MUL: val = rs * rt;
						ARITH_SUB: val = rs - rt;
						ARITH_DIV: val = (rt != 0) ? rs / rt : 16'd0;
						default: val = rs + sx(insn, 5);
					endcase
				end
				OP_CMP: begin
					case (insn[8:7])
						CMP_S: psr_q[2:0] = order3(1'b1, rd, rt);
						CMP_U: psr_q[2:0] = order3(1'b0, rd, rt);
						CMP_IS: psr_q[2:0] = order3(1'b1, rd, sx(insn, 7));
						default: psr_q[2:0] = order3(1'b0, rd, {9'd0, insn[6:0]});
					endcase
				end
				OP_JSR: begin
					wr = 1'b1;
					widx = 3'd7;
					val = pc1;
					npc = insn[11] ? {pc_view[15], insn[10:0], 4'd0} : rs;
				end
				OP_LOGIC: begin
					wr = 1'b1;
					case (sub)
						LOGIC_AND: val = rs & rt;
						LOGIC_NOT: val = ~rs;
						LOGIC_OR: val = rs | rt;
						LOGIC_XOR: val = rs ^ rt;
						default: val = rs & sx(insn, 5);
					endcase
				end
				OP_LDR: begin
					wr = 1'b1;
					val = mem_img[16'(rs + sx(insn, 6))];
				end
				OP_STR: begin
					st = 1'b1;
					saddr = rs + sx(insn, 6);
					mem_img[saddr] = rd;
				end
				OP_RTI: begin
					npc = reg_view[7];
					psr_q[15] = 1'b0;
				end
				OP_CONST: begin
					wr = 1'b1;
					val = sx(insn, 9);
				end
				OP_SHIFT: begin
					wr = 1'b1;
					case (insn[5:4])
						SH_SLL: val = rs << insn[3:0];
						SH_SRA: val = 16'($signed(rs) >>> insn[3:0]);
						SH_SRL: val = rs >> insn[3:0];
						default: val = (rt != 0) ? rs % rt : 16'd0;
					endcase
				end
				OP_JMP: npc = insn[11] ? pc1 + sx(insn, 11) : rs;
				OP_HICON: begin
					wr = 1'b1;
					val = {insn[7:0], rd[7:0]};
				end
				OP_TRAP: begin
					wr = 1'b1;
					widx = 3'd7;
					val = pc1;
					npc = {8'h80, insn[7:0]};
					psr_q[15] = 1'b1;
				end
				default: r.illegal = 1'b1;
			endcase
			if (!r.illegal) begin
				if (wr) begin
					reg_view[widx] = val;
					psr_q[2:0] = flags_of(val);
					r.reg_write = 1'b1;
					r.reg_index = widx;
					r.reg_value = val;
				end
				if (st) begin
					r.mem_write = 1'b1;
					r.store_addr = saddr;
					r.store_value = rd;
				end
				pc_view = npc;
			end
		end
		r.next_pc = pc_view;
		r.status_word = psr_q;
	endtask

	task automatic check_field(string nm, logic [15:0] e, logic [15:0] a);
		if (e !== a) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, nm, e, a);
			error_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t exp_r, got;
		if (!arst_n) begin
			pc_view = PC_RESET;
			psr_q = PSR_RESET;
			reg_view = '0;
			expected_q.delete();
			error_count = 0;
		end else begin
			if (in_mon.valid && in_mon.ready) begin
				run_item(item_t'(in_mon.data), exp_r);
				expected_q.push_back(exp_r);
			end
			if (out_mon.valid && out_mon.ready) begin
				got = result_t'(out_mon.data);
				if (expected_q.size() == 0) begin
					$display("%0t: result transfer with none expected, actual %h", $time, got);
					error_count++;
				end else begin
					exp_r = expected_q.pop_front();
					check_field("read_value", exp_r.read_value, got.read_value);
					check_field("next_pc", exp_r.next_pc, got.next_pc);
					check_field("status_word", exp_r.status_word, got.status_word);
					check_field("reg_write", 16'(exp_r.reg_write), 16'(got.reg_write));
					check_field("reg_index", 16'(exp_r.reg_index), 16'(got.reg_index));
					check_field("reg_value", exp_r.reg_value, got.reg_value);
					check_field("mem_write", 16'(exp_r.mem_write), 16'(got.mem_write));
					check_field("store_addr", exp_r.store_addr, got.store_addr);
					check_field("store_value", exp_r.store_value, got.store_value);
					check_field("illegal", 16'(exp_r.illegal), 16'(got.illegal));
				end
			end
		end
		pending = expected_q.size();
	end
endmodule

>>> tb/risc16_instruction_executor_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// risc16_instruction_executor_unit_test
// drives memory loads, reads and instruction runs into the executor, with
// random gaps on both channels; the checker predicts and compares results
// ----------------------------------------------------------------------------
module risc16_instruction_executor_unit_test;
	import rie_pkg::*;
	import rie_tb_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int error_count, pending, item_count;
	logic [15:0] pc_view;
	logic [7:0][15:0] reg_view;
	bit written [logic [15:0]];
	logic [15:0] written_q[$];
	bit no_idle;
	int stall_left;

	rie_stream_if #(.W($bits(item_t))) in_ch ();
	rie_stream_if #(.W($bits(result_t))) out_ch ();

	risc16_instruction_executor_unit uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch)
	);

	rie_exec_checker chk (
		.clk(clk), .arst_n(arst_n), .in_mon(in_ch), .out_mon(out_ch),
		.error_count(error_count), .pending(pending),
		.pc_view(pc_view), .reg_view(reg_view)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#4_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 19);
		if (no_idle || r < 12) return 0;
		if (r < 18) return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	// receiver stalls
	initial out_ch.ready = 1'b0;
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ch.ready <= 1'b0;
		end else if (!no_idle && $urandom_range(0, 3) == 0) begin
			stall_left <= gap_len();
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// one transfer, then an idle wait so the predicted state is settled
	task automatic send(input logic [1:0] f, input logic [15:0] a, input logic [15:0] v);
		item_t it;
		it.func = f;
		it.word_addr = a;
		it.load_value = v;
		repeat (gap_len()) @(posedge clk);
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		in_ch.valid <= 1'b0;
		@(posedge clk);
		item_count++;
		if (f == FUNC_LOAD && !written.exists(a)) begin
			written[a] = 1'b1;
			written_q.push_back(a);
		end
	endtask

	task automatic run_insn(input logic [15:0] insn);
		logic [15:0] target;
		send(FUNC_LOAD, pc_view, insn);
		target = reg_view[insn[8:6]] + {{10{insn[5]}}, insn[5:0]};
		if (insn[15:12] == OP_LDR && !written.exists(target))
			send(FUNC_LOAD, target, 16'($urandom()));
		send(FUNC_EXEC, 16'($urandom()), 16'($urandom()));
		if (insn[15:12] == OP_STR && !written.exists(target)) begin
			written[target] = 1'b1;
			written_q.push_back(target);
		end
	endtask

	function automatic logic [15:0] rand_insn();
		logic [15:0] w;
		w = 16'($urandom());
		// seed registers with constants now and then
		if ($urandom_range(0, 5) == 0) w[15:12] = OP_CONST;
		return w;
	endfunction

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		no_idle = 1'b0;
		stall_left = 0;
		item_count = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(FUNC_LOAD, 16'hFFFF, 16'hFFFF);
		send(FUNC_LOAD, 16'h0000, 16'h0000);
		send(FUNC_READ, 16'hFFFF, 16'h0000);
		send(FUNC_READ, 16'h0000, 16'hFFFF);
		send(FUNC_NONE, 16'hFFFF, 16'hFFFF);
		run_insn({OP_CONST, 3'd1, 9'h100});
		run_insn({OP_HICON, 3'd1, 1'b0, 8'h7F});
		run_insn({OP_CONST, 3'd2, 9'd3});
		run_insn({OP_ARITH, 3'd3, 3'd1, ARITH_ADD, 3'd2});
		run_insn({OP_ARITH, 3'd4, 3'd1, ARITH_MUL, 3'd2});
		run_insn({OP_ARITH, 3'd5, 3'd2, ARITH_SUB, 3'd1});
		run_insn({OP_ARITH, 3'd6, 3'd1, ARITH_DIV, 3'd2});
		run_insn({OP_ARITH, 3'd6, 3'd1, ARITH_DIV, 3'd0});
		run_insn({OP_ARITH, 3'd3, 3'd3, 1'b1, 5'h10});
		run_insn({OP_CMP, 3'd1, CMP_S, 4'd0, 3'd5});
		run_insn({OP_CMP, 3'd5, CMP_U, 4'd0, 3'd2});
		run_insn({OP_CMP, 3'd1, CMP_IS, 7'h40});
		run_insn({OP_CMP, 3'd2, CMP_IU, 7'h7F});
		run_insn({OP_LOGIC, 3'd3, 3'd1, LOGIC_AND, 3'd5});
		run_insn({OP_LOGIC, 3'd3, 3'd1, LOGIC_NOT, 3'd0});
		run_insn({OP_LOGIC, 3'd3, 3'd1, LOGIC_OR, 3'd2});
		run_insn({OP_LOGIC, 3'd3, 3'd1, LOGIC_XOR, 3'd5});
		run_insn({OP_LOGIC, 3'd3, 3'd5, 1'b1, 5'h1F});
		run_insn({OP_SHIFT, 3'd3, 3'd1, SH_SLL, 4'd15});
		run_insn({OP_SHIFT, 3'd3, 3'd5, SH_SRA, 4'd15});
		run_insn({OP_SHIFT, 3'd3, 3'd5, SH_SRL, 4'd1});
		run_insn({OP_SHIFT, 3'd3, 3'd1, SH_MOD, 1'b0, 3'd2});
		run_insn({OP_SHIFT, 3'd3, 3'd1, SH_MOD, 1'b0, 3'd0});
		run_insn({OP_STR, 3'd1, 3'd2, 6'h1F});
		run_insn({OP_LDR, 3'd4, 3'd2, 6'h1F});
		run_insn({OP_BR, 3'b111, 9'h005});
		run_insn({OP_BR, 3'b000, 9'h1FF});
		run_insn({OP_JSR, 1'b1, 11'h7FF});
		run_insn({OP_JSR, 1'b0, 2'd0, 3'd3, 6'd0});
		run_insn({OP_JMP, 1'b1, 11'h400});
		run_insn({OP_JMP, 1'b0, 2'd0, 3'd7, 6'd0});
		run_insn({OP_TRAP, 4'd0, 8'hFF});
		run_insn({OP_RTI, 12'd0});
		run_insn({OP_BAD_A, 12'hFFF});
		run_insn({OP_BAD_B, 12'h000});
		run_insn({OP_BAD_C, 12'h5A5});

		while (item_count < 1400) begin
			int r;
			r = $urandom_range(0, 19);
			if (item_count > 700 && item_count < 720) begin
				// hold off until the executor has drained
				while (pending != 0) @(posedge clk);
			end
			no_idle = (item_count % 300) > 240;
			if (r == 0)
				send(FUNC_LOAD, 16'($urandom()), 16'($urandom()));
			else if (r < 3)
				send(FUNC_READ, written_q[$urandom_range(0, written_q.size() - 1)],
					16'($urandom()));
			else if (r == 3)
				send(FUNC_NONE, 16'($urandom()), 16'($urandom()));
			else
				run_insn(rand_insn());
		end

		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
